/* rtl/ingf_pkg.sv */
// ----------------------------------------------------------------------------
// ingf_pkg: shared types for the normal gap filler
// Holds the command that the front part hands to the back part when a
// valid point closes a gap (or arrives with no gap at all).
// ----------------------------------------------------------------------------
package ingf_pkg;

  // Width of the held-point count; a gap never holds more than 63 points.
  localparam int CNT_W = 6;

  // Normal vector, component 0 is x.
  typedef logic [2:0][15:0] normal_t;

  // One gap-close command: the valid point and the fill of its gap.
  typedef struct packed {
    logic [15:0]      idx;        // index of the valid point
    logic [15:0]      gap_start;  // index of the first held point
    logic [CNT_W-1:0] count;      // number of held points to fill
    logic             ovf;        // the gap lost points
    normal_t          nrm;        // normal of the valid point
    normal_t          mid;        // interpolated normal for held points
  } cmd_t;

endpackage

/* rtl/ingf_ram.sv */
// ----------------------------------------------------------------------------
// ingf_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module ingf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 63
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ingf_front.sv */
// ----------------------------------------------------------------------------
// ingf_front: point intake and classification
// Tracks the path state, stores positions of held invalid points, and
// issues a command for every valid point.
// ----------------------------------------------------------------------------
module ingf_front import ingf_pkg::*; #(
  parameter int MAX_GAP     = 63,
  parameter int COORD_WIDTH = 16,
  parameter int AW          = (MAX_GAP > 1 ? $clog2(MAX_GAP) : 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [2:0][15:0]             pos,
  input  normal_t                      nrm,
  input  logic                         normal_invalid,
  input  logic                         end_of_path,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [2:0][COORD_WIDTH-1:0]  ram_wdata,
  output logic                         push,
  output cmd_t                         cmd,
  output logic [2:0][COORD_WIDTH-1:0]  cmd_pos
);

  logic [15:0]      point_counter;
  normal_t          prev_normal;
  logic             have_valid;
  logic [CNT_W-1:0] pending_count;
  logic             overflow_seen;
  logic [15:0]      gap_start;
  logic             room;
  logic [2:0][COORD_WIDTH-1:0] pos_kept;
  normal_t          mid;

  // Positions are kept in the configured coordinate width.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pos_kept[c] = COORD_WIDTH'($unsigned(pos[c]));
    end
  end

  // Floor midpoint of the previous and current normal, per component.
  always_comb begin
    logic [16:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum    = {prev_normal[c][15], prev_normal[c]} + {nrm[c][15], nrm[c]};
      mid[c] = sum[16:1];
    end
  end

  assign room = pending_count < CNT_W'(MAX_GAP);

  // Held-point store write.
  assign ram_we    = accept && normal_invalid && have_valid && room;
  assign ram_waddr = pending_count[AW-1:0];
  assign ram_wdata = pos_kept;

  // Command for a valid point.
  assign push          = accept && !normal_invalid;
  assign cmd.idx       = point_counter;
  assign cmd.gap_start = gap_start;
  assign cmd.count     = pending_count;
  assign cmd.ovf       = overflow_seen;
  assign cmd.nrm       = nrm;
  assign cmd.mid       = mid;
  assign cmd_pos       = pos_kept;

  // Path state.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_counter <= '0;
      prev_normal   <= '0;
      have_valid    <= 1'b0;
      pending_count <= '0;
      overflow_seen <= 1'b0;
      gap_start     <= '0;
    end else if (accept) begin
      if (end_of_path) begin
        point_counter <= '0;
        prev_normal   <= '0;
        have_valid    <= 1'b0;
        pending_count <= '0;
        overflow_seen <= 1'b0;
        gap_start     <= '0;
      end else begin
        point_counter <= point_counter + 16'd1;
        if (normal_invalid) begin
          if (have_valid) begin
            if (room) begin
              if (pending_count == '0) begin
                gap_start <= point_counter;
              end
              pending_count <= pending_count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end else begin
          prev_normal   <= nrm;
          have_valid    <= 1'b1;
          pending_count <= '0;
          overflow_seen <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/ingf_queue.sv */
// ----------------------------------------------------------------------------
// ingf_queue: two-entry command queue
// Decouples the intake from the result sequencer.
// ----------------------------------------------------------------------------
module ingf_queue import ingf_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  cmd_t                        push_cmd,
  input  logic [2:0][COORD_WIDTH-1:0] push_pos,
  input  logic                        pop,
  output logic                        head_valid,
  output cmd_t                        head_cmd,
  output logic [2:0][COORD_WIDTH-1:0] head_pos,
  output logic                        full
);

  cmd_t                        ent_cmd [2];
  logic [2:0][COORD_WIDTH-1:0] ent_pos [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;

  assign head_valid = count != 2'd0;
  assign full       = count == 2'd2;
  assign head_cmd   = ent_cmd[rd_ptr];
  assign head_pos   = ent_pos[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_cmd[wr_ptr] <= push_cmd;
      ent_pos[wr_ptr] <= push_pos;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/ingf_back.sv */
// ----------------------------------------------------------------------------
// ingf_back: result sequencer
// Reads held positions back, emits the filled points and then the valid
// point, through one output register.
// ----------------------------------------------------------------------------
module ingf_back import ingf_pkg::*; #(
  parameter int MAX_GAP     = 63,
  parameter int COORD_WIDTH = 16,
  parameter int AW          = (MAX_GAP > 1 ? $clog2(MAX_GAP) : 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  cmd_t                        cmd,
  input  logic [2:0][COORD_WIDTH-1:0] cmd_pos,
  output logic                        pop,
  output logic                        busy,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [2:0][COORD_WIDTH-1:0] ram_rdata,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [15:0]                 point_index,
  output logic [2:0][15:0]            pos,
  output normal_t                     nrm,
  output logic                        was_filled,
  output logic                        gap_overflow,
  output logic                        run_last
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_FILL = 3'b010,
    B_LAST = 3'b100
  } bstate_t;

  bstate_t          state, state_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] k_plus;
  logic             out_free;
  logic             load_fill;
  logic             load_last;

  assign out_free = !result_valid || !result_stall;
  assign k_plus   = k + CNT_W'(1);
  assign busy     = state != B_IDLE;

  // Sequencer.
  always_comb begin
    state_next = state;
    k_next     = k;
    pop        = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    load_fill  = 1'b0;
    load_last  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          k_next = '0;
          if (cmd.count != '0) begin
            ram_re     = 1'b1;
            state_next = B_FILL;
          end else begin
            state_next = B_LAST;
          end
        end
      end
      B_FILL: begin
        if (out_free) begin
          load_fill = 1'b1;
          k_next    = k_plus;
          if (k_plus < cmd.count) begin
            ram_re    = 1'b1;
            ram_raddr = k_plus[AW-1:0];
          end else begin
            state_next = B_LAST;
          end
        end
      end
      B_LAST: begin
        if (out_free) begin
          load_last  = 1'b1;
          pop        = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_fill || load_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_fill) begin
      point_index  <= cmd.gap_start + 16'(k);
      for (int c = 0; c < 3; c++) begin
        pos[c] <= 16'(ram_rdata[c]);
      end
      nrm          <= cmd.mid;
      was_filled   <= 1'b1;
      gap_overflow <= cmd.ovf;
      run_last     <= 1'b0;
    end else if (load_last) begin
      point_index  <= cmd.idx;
      for (int c = 0; c < 3; c++) begin
        pos[c] <= 16'(cmd_pos[c]);
      end
      nrm          <= cmd.nrm;
      was_filled   <= 1'b0;
      gap_overflow <= cmd.ovf;
      run_last     <= 1'b1;
    end
  end

endmodule

/* rtl/invalid_normal_gap_fill_top.sv */
// A valid point with no gap reaches the output through the command queue and the result sequencer.
// A gap of held points drains one result per cycle while the output is not stalled,
// set by the one read port of the held-position RAM; the valid point follows the gap.
// Valid points enter back to back until the two-entry queue fills, then one per command popped.
// An invalid point waits while the sequencer or its command queue still holds work.
// Reset (rst, synchronous, active high) clears path state, queue and output valid.
// ----------------------------------------------------------------------------
// invalid_normal_gap_fill_top: fills invalid surface normals along a path
// Held invalid points get the floor midpoint of their valid neighbors' normals.
// ----------------------------------------------------------------------------
module invalid_normal_gap_fill_top import ingf_pkg::*; #(
  parameter int MAX_GAP     = 63,
  parameter int COORD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic               normal_invalid,
  input  logic               end_of_path,
  output logic               result_valid,
  input  logic               result_stall,
  output logic        [15:0] point_index,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               was_filled,
  output logic               gap_overflow,
  output logic               run_last
);

  localparam int AW = (MAX_GAP > 1 ? $clog2(MAX_GAP) : 1);

  logic                        accept;
  logic                        busy;
  logic                        back_busy;
  logic                        q_full;
  logic                        q_valid;
  logic                        push;
  logic                        pop;
  cmd_t                        push_cmd;
  cmd_t                        head_cmd;
  logic [2:0][COORD_WIDTH-1:0] push_pos;
  logic [2:0][COORD_WIDTH-1:0] head_pos;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [2:0][COORD_WIDTH-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [2:0][COORD_WIDTH-1:0] ram_rdata;
  logic [2:0][15:0]            in_pos;
  normal_t                     in_nrm;
  logic [2:0][15:0]            res_pos;
  normal_t                     res_nrm;

  // Held positions are only written while nothing reads them back.
  assign busy        = q_valid || back_busy;
  assign point_stall = q_full || (normal_invalid && busy);
  assign accept      = point_valid && !point_stall;

  assign in_pos = {pos_z, pos_y, pos_x};
  assign in_nrm = {normal_z, normal_y, normal_x};

  ingf_front #(
    .MAX_GAP     (MAX_GAP),
    .COORD_WIDTH (COORD_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .pos            (in_pos),
    .nrm            (in_nrm),
    .normal_invalid (normal_invalid),
    .end_of_path    (end_of_path),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .push           (push),
    .cmd            (push_cmd),
    .cmd_pos        (push_pos)
  );

  ingf_ram #(
    .WIDTH (3 * COORD_WIDTH),
    .DEPTH (MAX_GAP)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ingf_queue #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_pos   (push_pos),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .head_pos   (head_pos),
    .full       (q_full)
  );

  ingf_back #(
    .MAX_GAP     (MAX_GAP),
    .COORD_WIDTH (COORD_WIDTH),
    .AW          (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd          (head_cmd),
    .cmd_pos      (head_pos),
    .pop          (pop),
    .busy         (back_busy),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .point_index  (point_index),
    .pos          (res_pos),
    .nrm          (res_nrm),
    .was_filled   (was_filled),
    .gap_overflow (gap_overflow),
    .run_last     (run_last)
  );

  assign out_pos_x    = res_pos[0];
  assign out_pos_y    = res_pos[1];
  assign out_pos_z    = res_pos[2];
  assign out_normal_x = res_nrm[0];
  assign out_normal_y = res_nrm[1];
  assign out_normal_z = res_nrm[2];

`ifndef SYNTHESIS
  // The command queue is never pushed while full.
  a_no_q_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command queue pushed while full");

  // Held positions are never overwritten while the sequencer may read them.
  a_no_ram_race: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !busy)
    else $error("held position written while gap drains");

  // A filled point is never the last result of its item.
  a_fill_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && was_filled) |-> !run_last)
    else $error("filled point marked as last result");

  // The sequencer leaves idle only with a command present.
  a_start_with_cmd: assert property (@(posedge clk) disable iff (rst)
    ($rose(back_busy)) |-> $past(q_valid))
    else $error("sequencer started without a command");
`endif

endmodule

/* sim/gap_fill_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_fill_checker: result predictor and scoreboard for the normal gap filler
// Watches the point and result channels, keeps its own copy of the path state,
// predicts the results of every accepted point and compares them in order.
// ----------------------------------------------------------------------------
module gap_fill_checker import ingf_pkg::*; #(
  parameter int MAX_GAP = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  input  logic               point_stall,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic               normal_invalid,
  input  logic               end_of_path,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic        [15:0] point_index,
  input  logic signed [15:0] out_pos_x,
  input  logic signed [15:0] out_pos_y,
  input  logic signed [15:0] out_pos_z,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic signed [15:0] out_normal_z,
  input  logic               was_filled,
  input  logic               gap_overflow,
  input  logic               run_last,
  output int                 errors,
  output int                 waiting,
  output int                 checked,
  output int                 filled,
  output int                 overflowed
);

  localparam int SHOW_LIMIT = 50;

  // Position vector, component 0 is x.
  typedef logic [2:0][15:0] position_t;

  // One emitted point as the block should present it.
  typedef struct packed {
    logic [15:0] idx;
    position_t   pos;
    normal_t     nrm;
    logic        filled;
    logic        ovf;
    logic        last;
  } emitted_point_t;

  emitted_point_t expected_points[$];

  // Path state of the predictor.
  normal_t     last_normal;
  logic        have_valid;
  int          held_count;
  position_t   held_pos [0:MAX_GAP-1];
  logic [15:0] next_index;
  logic        gap_lost;
  logic [15:0] gap_first;

  int fail_count;
  int checked_count;
  int filled_count;
  int ovf_count;

  // Floor of the mean of two signed 16-bit values, exact in 17 bits.
  function automatic logic [15:0] floor_mid(logic [15:0] a, logic [15:0] b);
    logic signed [16:0] sum;
    sum = $signed({a[15], a}) + $signed({b[15], b});
    return sum[16:1];
  endfunction

  task automatic clear_path();
    last_normal = '0;
    have_valid  = 1'b0;
    held_count  = 0;
    next_index  = '0;
    gap_lost    = 1'b0;
    gap_first   = '0;
  endtask

  // Update the path state for one accepted point and queue its results.
  task automatic predict_point(position_t pos, normal_t nrm, logic inv, logic eop);
    logic [15:0]    idx;
    normal_t        mid;
    emitted_point_t r;
    idx = next_index;
    next_index = next_index + 16'd1;
    if (inv) begin
      // Invalid points are held only after a valid one, up to the gap limit.
      if (have_valid) begin
        if (held_count < MAX_GAP) begin
          if (held_count == 0) gap_first = idx;
          held_pos[held_count] = pos;
          held_count++;
        end else begin
          gap_lost = 1'b1;
        end
      end
    end else begin
      // A valid point closes the gap: held points first, then the point itself.
      if (have_valid) begin
        for (int c = 0; c < 3; c++) mid[c] = floor_mid(last_normal[c], nrm[c]);
        for (int k = 0; k < held_count; k++) begin
          r.idx    = gap_first + 16'(k);
          r.pos    = held_pos[k];
          r.nrm    = mid;
          r.filled = 1'b1;
          r.ovf    = gap_lost;
          r.last   = 1'b0;
          expected_points.insert(expected_points.size(), r);
        end
      end
      r.idx    = idx;
      r.pos    = pos;
      r.nrm    = nrm;
      r.filled = 1'b0;
      r.ovf    = gap_lost;
      r.last   = 1'b1;
      expected_points.insert(expected_points.size(), r);
      last_normal = nrm;
      have_valid  = 1'b1;
      held_count  = 0;
      gap_lost    = 1'b0;
    end
    if (eop) clear_path();
  endtask

  task automatic check_field(string name, logic [15:0] idx, logic [15:0] want,
                             logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
        $display("%0t: point %0d %s expected %h, got %h", $time, idx, name, want, got);
      end
      if (fail_count == SHOW_LIMIT) $display("Further mismatches are not shown.");
    end
  endtask

  always @(posedge clk) begin : scoreboard
    emitted_point_t want;
    if (rst) begin
      clear_path();
      expected_points.delete();
      fail_count    = 0;
      checked_count = 0;
      filled_count  = 0;
      ovf_count     = 0;
    end else begin
      // Compare an accepted result with the oldest prediction.
      if (result_valid && !result_stall) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("%0t: result for point %0d arrived with none expected",
                     $time, point_index);
          end
        end else begin
          want = expected_points.pop_front();
          check_field("point_index", want.idx, want.idx, point_index);
          check_field("out_pos_x", want.idx, want.pos[0], out_pos_x);
          check_field("out_pos_y", want.idx, want.pos[1], out_pos_y);
          check_field("out_pos_z", want.idx, want.pos[2], out_pos_z);
          check_field("out_normal_x", want.idx, want.nrm[0], out_normal_x);
          check_field("out_normal_y", want.idx, want.nrm[1], out_normal_y);
          check_field("out_normal_z", want.idx, want.nrm[2], out_normal_z);
          check_field("was_filled", want.idx, {15'd0, want.filled}, {15'd0, was_filled});
          check_field("gap_overflow", want.idx, {15'd0, want.ovf}, {15'd0, gap_overflow});
          check_field("run_last", want.idx, {15'd0, want.last}, {15'd0, run_last});
          checked_count++;
          if (want.filled) filled_count++;
          if (want.ovf) ovf_count++;
        end
      end
      // Predict the results of an accepted point.
      if (point_valid && !point_stall) begin
        predict_point({pos_z, pos_y, pos_x}, {normal_z, normal_y, normal_x},
                      normal_invalid, end_of_path);
      end
    end
    errors     <= fail_count;
    waiting    <= expected_points.size();
    checked    <= checked_count;
    filled     <= filled_count;
    overflowed <= ovf_count;
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the normal gap filler
// Sends directed paths, one path whose gaps fill and overflow the held-point
// buffer, and short random paths, with random sender gaps and receiver
// stalls. Checking is done by gap_fill_checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_GAP        = 63;
  localparam int ITEM_COUNT     = 170;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               point_valid = 1'b0;
  logic               point_stall;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] pos_z = '0;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic signed [15:0] normal_z = '0;
  logic               normal_invalid = 1'b0;
  logic               end_of_path = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic        [15:0] point_index;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic signed [15:0] out_pos_z;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic signed [15:0] out_normal_z;
  logic               was_filled;
  logic               gap_overflow;
  logic               run_last;

  int errors;
  int waiting;
  int checked;
  int filled;
  int overflowed;

  int          idle_cycles = 0;
  int          burst_left = 0;
  int          points_sent = 0;
  int          paths_sent = 0;
  logic        path_flags[$];
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_timer = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  invalid_normal_gap_fill_top #(
    .MAX_GAP     (MAX_GAP),
    .COORD_WIDTH (16)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .point_valid    (point_valid),
    .point_stall    (point_stall),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .normal_x       (normal_x),
    .normal_y       (normal_y),
    .normal_z       (normal_z),
    .normal_invalid (normal_invalid),
    .end_of_path    (end_of_path),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .point_index    (point_index),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .was_filled     (was_filled),
    .gap_overflow   (gap_overflow),
    .run_last       (run_last)
  );

  gap_fill_checker #(
    .MAX_GAP (MAX_GAP)
  ) checker_inst (
    .clk            (clk),
    .rst            (rst),
    .point_valid    (point_valid),
    .point_stall    (point_stall),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .normal_x       (normal_x),
    .normal_y       (normal_y),
    .normal_z       (normal_z),
    .normal_invalid (normal_invalid),
    .end_of_path    (end_of_path),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .point_index    (point_index),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .was_filled     (was_filled),
    .gap_overflow   (gap_overflow),
    .run_last       (run_last),
    .errors         (errors),
    .waiting        (waiting),
    .checked        (checked),
    .filled         (filled),
    .overflowed     (overflowed)
  );

  // Receiver stalls: the mode changes when a random timer runs out, one mode never stalls.
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(20, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      STALL_NONE:     result_stall <= 1'b0;
      STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
      STALL_PERIODIC: result_stall <= (stall_timer % 3 == 0);
      default:        result_stall <= 1'b0;
    endcase
  end

  // Watchdog: the run ends if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Field value with extra weight on the extremes.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Append one flag (1 = invalid normal) to the path being built.
  task automatic add_flag(logic f);
    path_flags.insert(path_flags.size(), f);
  endtask

  // Send one point; bursts of random length are mostly separated by random gaps.
  task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                            logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic inv, logic eop);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        point_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    point_valid    <= 1'b1;
    pos_x          <= px;
    pos_y          <= py;
    pos_z          <= pz;
    normal_x       <= nx;
    normal_y       <= ny;
    normal_z       <= nz;
    normal_invalid <= inv;
    end_of_path    <= eop;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    points_sent++;
  endtask

  // Send the path held in path_flags (1 = invalid normal) with random content.
  task automatic send_path();
    for (int i = 0; i < path_flags.size(); i++) begin
      send_point(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), path_flags[i], i == path_flags.size() - 1);
    end
    path_flags.delete();
    paths_sent++;
  endtask

  initial begin
    int lead;
    int body;
    int gap;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: leading invalid points, extreme midpoints, fill at end of path.
    send_point(16'h7FFF, 16'h8000, 16'h0001, 16'h1234, 16'h5678, 16'h9ABC, 1'b1, 1'b0);
    send_point(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_point(16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
    send_point(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_point(16'h0100, 16'hFF00, 16'h1000, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 1'b0, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0);
    send_point(16'hFFFF, 16'h0000, 16'h8000, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0);
    send_point(16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 16'h0000, 16'h0001, 1'b0, 1'b1);
    // A path of one valid point.
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1);
    // Trailing invalid points are dropped at the end of the path.
    send_point(16'h4000, 16'hC000, 16'h2000, 16'h4000, 16'hC000, 16'h0000, 1'b0, 1'b0);
    send_point(16'h0001, 16'h0002, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_point(16'h0004, 16'h0005, 16'h0006, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    // A path made of a single invalid point.
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    // Valid point that closes a gap and ends the path.
    send_point(16'h0F0F, 16'hF0F0, 16'h00FF, 16'h4000, 16'h4000, 16'hC000, 1'b0, 1'b0);
    send_point(16'h3333, 16'hCCCC, 16'h6666, 16'h1111, 16'h2222, 16'h3333, 1'b1, 1'b0);
    send_point(16'hFF00, 16'h00FF, 16'h0F0F, 16'hC001, 16'hBFFF, 16'h4001, 1'b0, 1'b1);

    // A gap that exactly fills the buffer, one that overflows it, then a short one.
    add_flag(1'b0);
    repeat (MAX_GAP) add_flag(1'b1);
    add_flag(1'b0);
    repeat (MAX_GAP + 1) add_flag(1'b1);
    add_flag(1'b0);
    repeat (2) add_flag(1'b1);
    add_flag(1'b0);
    send_path();

    // Random paths: mostly well formed with short gaps, some pure noise.
    while (points_sent < ITEM_COUNT) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) add_flag(1'($urandom_range(0, 1)));
      end else begin
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lead) add_flag(1'b1);
        add_flag(1'b0);
        body = $urandom_range(1, 6);
        while (body > 0) begin
          if ($urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
            repeat (gap) add_flag(1'b1);
          end
          add_flag(1'b0);
          body--;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) add_flag(1'b1);
        end
      end
      send_path();
    end

    // Drain: wait for every predicted result, then watch for stray ones.
    point_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d points in %0d paths, including a full and an overflowing gap.",
             points_sent, paths_sent);
    $display("Checked %0d results: %0d with filled normals, %0d flagged for lost points.",
             checked, filled, overflowed);
    if (waiting != 0) $display("%0d expected results never arrived", waiting);
    if (errors == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
